[hw/rtl/tkq_pkg.sv]
// Shared types, constants and helpers for the touch key code qualifier.
package tkq_pkg;

	// Scan payload layout
	localparam int SAMPLE_FIELDS = 5;
	localparam int VOTE_SAMPLES  = 5;
	localparam int USED_SAMPLES  = (VOTE_SAMPLES < SAMPLE_FIELDS) ? VOTE_SAMPLES : SAMPLE_FIELDS;
	localparam int CODE_W        = 3;
	localparam int SAMPLES_W     = SAMPLE_FIELDS * CODE_W;
	localparam int NUM_CH        = 1 << CODE_W;
	localparam int CH_W          = CODE_W + 1;
	localparam int VCNT_W        = $clog2(USED_SAMPLES + 1);
	localparam int BYTE_W        = 8;

	// Configuration port
	localparam int PDATA_W = 64;
	localparam int PADDR_W = 5;
	localparam int REG_W   = PADDR_W - 3;

	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [CH_W-1:0]    ch_t;
	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [VCNT_W-1:0]  vcnt_t;
	typedef vcnt_t              vcnt_arr_t [NUM_CH];
	typedef logic [REG_W-1:0]   reg_idx_t;

	localparam ch_t   NONE_CH = ch_t'(NUM_CH);
	localparam byte_t SAT_MAX = '1;

	localparam reg_idx_t REG_KEY_MAP         = reg_idx_t'(0);
	localparam reg_idx_t REG_FLAG_ACTIVE_LOW = reg_idx_t'(1);
	localparam reg_idx_t REG_STABLE_NEEDED   = reg_idx_t'(2);
	localparam reg_idx_t REG_SETTLE_SCANS    = reg_idx_t'(3);

	localparam byte_t STABLE_NEEDED_RST = byte_t'(2);
	localparam byte_t SETTLE_SCANS_RST  = byte_t'(2);

	// Histogram control and status
	typedef struct packed {
		logic  clear;
		logic  inc;
		code_t idx;
		logic  start;
	} hist_cmd_t;

	typedef struct packed {
		logic busy;
		ch_t  winner;
	} hist_stat_t;

	function automatic byte_t map_key(input logic [PDATA_W-1:0] km, input code_t ch);
		return km[BYTE_W*ch +: BYTE_W];
	endfunction

endpackage

[hw/rtl/tkq_ifs.sv]
// Scan input and key result channel interfaces.
interface tkq_in_if;
	logic                           valid;
	logic                           ready;
	logic                           flag_pin;
	logic [tkq_pkg::SAMPLES_W-1:0]  code_samples;

	modport source (output valid, flag_pin, code_samples, input ready);
	modport sink (input valid, flag_pin, code_samples, output ready);
endinterface

interface tkq_out_if;
	logic                 valid;
	logic                 ready;
	logic                 key_valid;
	tkq_pkg::byte_t       key_code;
	tkq_pkg::ch_t         held_channel;
	logic                 release_valid;
	tkq_pkg::code_t       release_channel;
	tkq_pkg::byte_t       release_key;

	modport source (output valid, key_valid, key_code, held_channel, release_valid,
		release_channel, release_key, input ready);
	modport sink (input valid, key_valid, key_code, held_channel, release_valid,
		release_channel, release_key, output ready);
endinterface

[hw/rtl/tkq_vote_lane.sv]
// One vote lane: counts the samples of a scan that carry this lane's code.
module tkq_vote_lane (
	input  logic                          clk,
	input  logic                          load,
	input  tkq_pkg::code_t                lane_code,
	input  logic [tkq_pkg::SAMPLES_W-1:0] samples,
	output tkq_pkg::vcnt_t                count_s1
);
	tkq_pkg::vcnt_t count_c;

	always_comb begin
		count_c = '0;
		for (int k = 0; k < tkq_pkg::USED_SAMPLES; k++) begin
			count_c = count_c + tkq_pkg::vcnt_t'(samples[tkq_pkg::CODE_W*k +: tkq_pkg::CODE_W]
				== lane_code);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			count_s1 <= count_c;
		end
	end
endmodule

[hw/rtl/tkq_vote_merge.sv]
// Vote merge: highest lane count wins, lowest code on a tie.
module tkq_vote_merge (
	input  logic                clk,
	input  logic                load,
	input  tkq_pkg::vcnt_arr_t  counts,
	input  tkq_pkg::code_t      sample0,
	output tkq_pkg::code_t      vote_s2
);
	tkq_pkg::vcnt_t top_n;
	tkq_pkg::code_t best;
	logic           found;

	always_comb begin
		top_n = '0;
		best  = '0;
		found = 1'b0;
		for (int k = 0; k < tkq_pkg::NUM_CH; k++) begin
			if (counts[k] > top_n) begin
				top_n = counts[k];
				best  = tkq_pkg::code_t'(k);
				found = 1'b1;
			end
		end
	end

	// fall back to the first sample when no sample took part
	always_ff @(posedge clk) begin
		if (load) begin
			vote_s2 <= found ? best : sample0;
		end
	end
endmodule

[hw/rtl/tkq_hist.sv]
// Release histogram: eight saturating bins and a one-bin-per-cycle winner search.
module tkq_hist (
	input  logic                clk,
	input  logic                arst_n,
	input  tkq_pkg::hist_cmd_t  cmd,
	output tkq_pkg::hist_stat_t stat
);
	tkq_pkg::byte_t bins_q [tkq_pkg::NUM_CH];
	tkq_pkg::byte_t bins_c [tkq_pkg::NUM_CH];
	logic           busy_q;
	tkq_pkg::code_t k_q;
	tkq_pkg::byte_t top_n_q;
	tkq_pkg::ch_t   best_q;

	always_comb begin
		for (int k = 0; k < tkq_pkg::NUM_CH; k++) begin
			bins_c[k] = cmd.clear ? '0 : bins_q[k];
			if (cmd.inc && cmd.idx == tkq_pkg::code_t'(k) && bins_c[k] != tkq_pkg::SAT_MAX) begin
				bins_c[k] = bins_c[k] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < tkq_pkg::NUM_CH; k++) begin
				bins_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < tkq_pkg::NUM_CH; k++) begin
				bins_q[k] <= bins_c[k];
			end
		end
	end

	// walk the bins in index order; strict compare keeps the lowest index on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			k_q     <= '0;
			top_n_q <= '0;
			best_q  <= tkq_pkg::NONE_CH;
		end else if (cmd.start) begin
			busy_q  <= 1'b1;
			k_q     <= '0;
			top_n_q <= '0;
			best_q  <= tkq_pkg::NONE_CH;
		end else if (busy_q) begin
			if (bins_q[k_q] > top_n_q) begin
				top_n_q <= bins_q[k_q];
				best_q  <= {1'b0, k_q};
			end
			if (k_q == tkq_pkg::code_t'(tkq_pkg::NUM_CH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	assign stat.busy   = busy_q;
	assign stat.winner = best_q;
endmodule

[hw/rtl/touch_key_code_qualifier_unit.sv]
// Top level of the touch key code qualifier: vote lanes, merge, histogram and scan tracking.
//
//   channel   dir   handshake       beat contents
//   scan_in   in    valid/ready     flag_pin, code_samples (five 3-bit samples)
//   key_out   out   valid/ready     key_valid, key_code, held_channel,
//                                   release_valid, release_channel, release_key
//   apb       in    psel/penable    key_map, flag_active_low, stable_needed, settle_scans
//
// An ordinary scan passes through accept (lanes count), vote merge and commit.
// A release scan of an active press also runs the histogram winner search, which
// visits one bin per cycle over all eight bins before commit.
// Reset (arst_n low) returns registers to their defaults and clears all tracking.
// The result sits in an output register; the next scan is accepted while it waits.
// Commit stalls only while the output register is still full and not taken.
module touch_key_code_qualifier_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	tkq_in_if.sink                        scan_in,
	tkq_out_if.source                     key_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tkq_pkg::PADDR_W-1:0]   paddr,
	input  logic [tkq_pkg::PDATA_W-1:0]   pwdata,
	output logic [tkq_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_VOTE   = 4'b0010,
		S_SEARCH = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [tkq_pkg::PDATA_W-1:0] key_map_q;
	logic                        flag_active_low_q;
	tkq_pkg::byte_t              stable_needed_q;
	tkq_pkg::byte_t              settle_scans_q;
	tkq_pkg::reg_idx_t           reg_idx;
	logic                        cfg_wr;

	// tracking state
	logic           prev_pressed_q;
	logic           in_press_q;
	tkq_pkg::byte_t settle_left_q;
	tkq_pkg::ch_t   held_q;
	tkq_pkg::ch_t   sample_q;
	tkq_pkg::byte_t stable_cnt_q;

	// scan in flight
	logic                in_fire;
	logic                pressed_q;
	tkq_pkg::code_t      sample0_q;
	tkq_pkg::vcnt_arr_t  lane_cnt_s1;
	tkq_pkg::code_t      vote_s2;

	tkq_pkg::hist_cmd_t  hist_cmd;
	tkq_pkg::hist_stat_t hist_st;

	// output register
	logic           out_valid_q;
	logic           key_valid_q;
	tkq_pkg::byte_t key_code_q;
	tkq_pkg::ch_t   held_channel_q;
	logic           release_valid_q;
	tkq_pkg::code_t release_channel_q;
	tkq_pkg::byte_t release_key_q;

	// commit results
	logic           commit_go;
	logic           release_scan;
	logic           press_edge;
	logic           track;
	logic           stable_n;
	logic           stable_old;
	logic           pa_n;
	tkq_pkg::byte_t sl_e;
	tkq_pkg::byte_t sl_n;
	tkq_pkg::ch_t   held_e;
	tkq_pkg::ch_t   held_n;
	tkq_pkg::ch_t   samp_e;
	tkq_pkg::ch_t   samp_n;
	tkq_pkg::byte_t cnt_e;
	tkq_pkg::byte_t cnt_n;
	tkq_pkg::ch_t   rel_ch;
	logic           kv_c;
	tkq_pkg::ch_t   hc_c;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[tkq_pkg::PADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_map_q         <= '0;
			flag_active_low_q <= 1'b1;
			stable_needed_q   <= tkq_pkg::STABLE_NEEDED_RST;
			settle_scans_q    <= tkq_pkg::SETTLE_SCANS_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				tkq_pkg::REG_KEY_MAP:         key_map_q <= pwdata;
				tkq_pkg::REG_FLAG_ACTIVE_LOW: flag_active_low_q <= pwdata[0];
				tkq_pkg::REG_STABLE_NEEDED:   stable_needed_q <= pwdata[tkq_pkg::BYTE_W-1:0];
				tkq_pkg::REG_SETTLE_SCANS:    settle_scans_q <= pwdata[tkq_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tkq_pkg::REG_KEY_MAP:         prdata = key_map_q;
			tkq_pkg::REG_FLAG_ACTIVE_LOW: prdata = tkq_pkg::PDATA_W'(flag_active_low_q);
			tkq_pkg::REG_STABLE_NEEDED:   prdata = tkq_pkg::PDATA_W'(stable_needed_q);
			tkq_pkg::REG_SETTLE_SCANS:    prdata = tkq_pkg::PDATA_W'(settle_scans_q);
			default:                      prdata = '0;
		endcase
	end

	// ---------------- vote lanes and merge ----------------
	assign scan_in.ready = (state_q == S_IDLE);
	assign in_fire       = scan_in.valid && scan_in.ready;

	for (genvar g = 0; g < tkq_pkg::NUM_CH; g++) begin : g_lane
		tkq_vote_lane u_lane (
			.clk       (clk),
			.load      (in_fire),
			.lane_code (tkq_pkg::code_t'(g)),
			.samples   (scan_in.code_samples),
			.count_s1  (lane_cnt_s1[g])
		);
	end

	tkq_vote_merge u_merge (
		.clk     (clk),
		.load    (state_q == S_VOTE),
		.counts  (lane_cnt_s1),
		.sample0 (sample0_q),
		.vote_s2 (vote_s2)
	);

	// capture the press level with the polarity in force when the scan arrives
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pressed_q <= flag_active_low_q ? !scan_in.flag_pin : scan_in.flag_pin;
			sample0_q <= scan_in.code_samples[tkq_pkg::CODE_W-1:0];
		end
	end

	// ---------------- release histogram ----------------
	assign release_scan = !pressed_q && prev_pressed_q && in_press_q;

	tkq_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hist_cmd),
		.stat   (hist_st)
	);

	// ---------------- commit logic ----------------
	assign commit_go = (state_q == S_COMMIT) && (!out_valid_q || key_out.ready);
	assign press_edge = pressed_q && !prev_pressed_q;

	always_comb begin
		// a press edge restarts tracking and loads the settle countdown
		pa_n   = press_edge ? 1'b1 : in_press_q;
		sl_e   = press_edge ? settle_scans_q : settle_left_q;
		held_e = press_edge ? tkq_pkg::NONE_CH : held_q;
		samp_e = press_edge ? tkq_pkg::NONE_CH : sample_q;
		cnt_e  = press_edge ? '0 : stable_cnt_q;

		track  = (sl_e == '0);
		sl_n   = track ? sl_e : sl_e - 1'b1;
		held_n = held_e;
		samp_n = samp_e;
		cnt_n  = cnt_e;
		if (track) begin
			if ({1'b0, vote_s2} == samp_e) begin
				if (cnt_e != tkq_pkg::SAT_MAX) begin
					cnt_n = cnt_e + 1'b1;
				end
			end else begin
				samp_n = {1'b0, vote_s2};
				cnt_n  = tkq_pkg::byte_t'(1);
			end
		end
		stable_n = (cnt_n >= stable_needed_q);
		if (track && stable_n) begin
			held_n = {1'b0, vote_s2};
		end
		kv_c = stable_n && (held_n != tkq_pkg::NONE_CH);
		hc_c = (kv_c && sl_n == '0) ? held_n : tkq_pkg::NONE_CH;

		// release pick: held, then stable sample, then histogram winner below seven
		stable_old = (stable_cnt_q >= stable_needed_q);
		if (held_q != tkq_pkg::NONE_CH) begin
			rel_ch = held_q;
		end else if (stable_old && sample_q != tkq_pkg::NONE_CH) begin
			rel_ch = sample_q;
		end else if (hist_st.winner < tkq_pkg::ch_t'(tkq_pkg::NUM_CH - 1)) begin
			rel_ch = hist_st.winner;
		end else begin
			rel_ch = tkq_pkg::NONE_CH;
		end
		if (!release_scan) begin
			rel_ch = tkq_pkg::NONE_CH;
		end

		hist_cmd.start = (state_q == S_VOTE) && release_scan;
		hist_cmd.clear = commit_go && (!pressed_q || press_edge);
		hist_cmd.inc   = commit_go && pressed_q && track && stable_n;
		hist_cmd.idx   = vote_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			prev_pressed_q <= 1'b0;
			in_press_q     <= 1'b0;
			settle_left_q  <= '0;
			held_q         <= tkq_pkg::NONE_CH;
			sample_q       <= tkq_pkg::NONE_CH;
			stable_cnt_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (key_out.ready && !commit_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_VOTE;
					end
				end
				S_VOTE: begin
					state_q <= release_scan ? S_SEARCH : S_COMMIT;
				end
				S_SEARCH: begin
					if (!hist_st.busy) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (commit_go) begin
						state_q        <= S_IDLE;
						out_valid_q    <= 1'b1;
						prev_pressed_q <= pressed_q;
						if (pressed_q) begin
							in_press_q     <= pa_n;
							settle_left_q  <= sl_n;
							held_q         <= held_n;
							sample_q       <= samp_n;
							stable_cnt_q   <= cnt_n;
						end else begin
							in_press_q     <= 1'b0;
							settle_left_q  <= '0;
							held_q         <= tkq_pkg::NONE_CH;
							sample_q       <= tkq_pkg::NONE_CH;
							stable_cnt_q   <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result beat payload; zero the fields that carry no event, held channel reads NONE_CH
	always_ff @(posedge clk) begin
		if (commit_go) begin
			key_valid_q       <= pressed_q && kv_c;
			key_code_q        <= (pressed_q && kv_c) ?
				tkq_pkg::map_key(key_map_q, held_n[tkq_pkg::CODE_W-1:0]) : '0;
			held_channel_q    <= pressed_q ? hc_c : tkq_pkg::NONE_CH;
			release_valid_q   <= (rel_ch != tkq_pkg::NONE_CH);
			release_channel_q <= (rel_ch != tkq_pkg::NONE_CH) ?
				rel_ch[tkq_pkg::CODE_W-1:0] : '0;
			release_key_q     <= (rel_ch != tkq_pkg::NONE_CH) ?
				tkq_pkg::map_key(key_map_q, rel_ch[tkq_pkg::CODE_W-1:0]) : '0;
		end
	end

	assign key_out.valid           = out_valid_q;
	assign key_out.key_valid       = key_valid_q;
	assign key_out.key_code        = key_code_q;
	assign key_out.held_channel    = held_channel_q;
	assign key_out.release_valid   = release_valid_q;
	assign key_out.release_channel = release_channel_q;
	assign key_out.release_key     = release_key_q;

	// ---------------- assertions ----------------
	a_settle_in_press: assert property (@(posedge clk) disable iff (!arst_n)
		settle_left_q != '0 |-> in_press_q)
		else $error("settle countdown running outside a press");

	a_key_xor_release: assert property (@(posedge clk) disable iff (!arst_n)
		key_out.valid && key_out.key_valid |-> !key_out.release_valid)
		else $error("key and release reported in the same beat");

	a_held_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		key_out.valid && key_out.held_channel != tkq_pkg::NONE_CH |-> key_out.key_valid)
		else $error("held channel reported without a valid key");

	a_search_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_SEARCH |-> !hist_st.busy)
		else $error("histogram search busy outside the search state");
endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the touch key code qualifier unit.
module testbench;
	import tkq_pkg::*;

	typedef struct packed {
		logic  key_valid;
		byte_t key_code;
		ch_t   held_channel;
		logic  release_valid;
		code_t release_channel;
		byte_t release_key;
	} key_result_t;

	typedef struct packed {
		logic                 pin;
		logic [SAMPLES_W-1:0] smp;
		logic                 typed;
		key_result_t          want;
	} stim_row_t;

	localparam key_result_t NO_KEY = key_result_t'({1'b0, 8'h00, NONE_CH, 1'b0, 3'd0, 8'h00});
	localparam logic [PDATA_W-1:0] DIRECTED_MAP = 64'h8070_6050_4030_2010;
	localparam int STALL_PCT   = 8;
	localparam int QUIET_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	tkq_in_if  scan_if ();
	tkq_out_if key_if ();

	touch_key_code_qualifier_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan_in (scan_if),
		.key_out (key_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the configuration registers
	logic [PDATA_W-1:0] cfg_key_map;
	logic               cfg_active_low;
	byte_t              cfg_stable_needed;
	byte_t              cfg_settle_scans;

	// Shadow of the tracking state
	logic  prev_pressed;
	logic  in_press;
	byte_t settle_left;
	ch_t   held_code;
	ch_t   sample_code;
	byte_t stable_count;
	byte_t rel_hist [NUM_CH];

	key_result_t pending_keys [$];
	stim_row_t   plan [$];
	int          mismatch_count;
	int          scans_sent;
	int          quiet_cycles;
	logic        steady;

	always #6 clk = ~clk;

	function automatic byte_t key_byte(input code_t ch);
		return cfg_key_map[BYTE_W*ch +: BYTE_W];
	endfunction

	function automatic logic run_is_stable();
		return stable_count >= cfg_stable_needed;
	endfunction

	function automatic void tracking_clear();
		held_code = NONE_CH;
		sample_code = NONE_CH;
		stable_count = '0;
		foreach (rel_hist[k]) rel_hist[k] = '0;
	endfunction

	// Most frequent code among the used samples; the lowest code wins a tie.
	function automatic code_t majority_code(input logic [SAMPLES_W-1:0] smp);
		int tally [NUM_CH];
		int best_n;
		code_t best;
		foreach (tally[c]) tally[c] = 0;
		for (int k = 0; k < USED_SAMPLES; k++) tally[smp[CODE_W*k +: CODE_W]]++;
		best = smp[CODE_W-1:0];
		best_n = 0;
		for (int c = 0; c < NUM_CH; c++) begin
			if (tally[c] > best_n) begin
				best_n = tally[c];
				best = code_t'(c);
			end
		end
		return best;
	endfunction

	function automatic ch_t hist_leader();
		int best_n;
		ch_t best;
		best_n = 0;
		best = NONE_CH;
		for (int k = 0; k < NUM_CH; k++) begin
			if (rel_hist[k] > best_n) begin
				best_n = rel_hist[k];
				best = ch_t'(k);
			end
		end
		return best;
	endfunction

	// Advance the shadow state by one scan and work out its key result.
	function automatic void qualify_scan(input logic pin, input logic [SAMPLES_W-1:0] smp,
		output key_result_t res);
		logic  pressed;
		code_t vcode;
		ch_t   pick;
		pressed = cfg_active_low ? !pin : pin;
		res = NO_KEY;
		if (pressed) begin
			if (!prev_pressed) begin
				in_press = 1'b1;
				settle_left = cfg_settle_scans;
				tracking_clear();
			end
			if (settle_left != 0) begin
				settle_left--;
			end else begin
				vcode = majority_code(smp);
				if (ch_t'(vcode) == sample_code) begin
					if (stable_count != SAT_MAX) stable_count++;
				end else begin
					sample_code = ch_t'(vcode);
					stable_count = 8'd1;
				end
				if (run_is_stable()) begin
					held_code = ch_t'(vcode);
					if (rel_hist[vcode] != SAT_MAX) rel_hist[vcode]++;
				end
			end
			if (run_is_stable() && held_code < NONE_CH) begin
				res.key_valid = 1'b1;
				res.key_code = key_byte(held_code[CODE_W-1:0]);
				if (settle_left == 0) res.held_channel = held_code;
			end
		end else begin
			if (prev_pressed) begin
				pick = NONE_CH;
				if (held_code >= NONE_CH && run_is_stable() && sample_code < NONE_CH)
					held_code = sample_code;
				if (in_press) begin
					if (held_code < NONE_CH) begin
						pick = held_code;
					end else if (run_is_stable() && sample_code < NONE_CH) begin
						pick = sample_code;
					end else begin
						// the histogram never names the top channel
						pick = hist_leader();
						if (pick == ch_t'(NUM_CH - 1)) pick = NONE_CH;
					end
					if (pick < NONE_CH) begin
						res.release_valid = 1'b1;
						res.release_channel = pick[CODE_W-1:0];
						res.release_key = key_byte(pick[CODE_W-1:0]);
					end
				end
			end
			in_press = 1'b0;
			settle_left = '0;
			tracking_clear();
		end
		prev_pressed = pressed;
	endfunction

	function automatic logic [SAMPLES_W-1:0] pack5(input code_t c0, c1, c2, c3, c4);
		return {c4, c3, c2, c1, c0};
	endfunction

	// Mostly the lead code; strict keeps it in three slots so it always wins.
	function automatic logic [SAMPLES_W-1:0] vote_mix(input code_t lead, input logic strict);
		logic [SAMPLES_W-1:0] smp;
		for (int k = 0; k < SAMPLE_FIELDS; k++) begin
			if ((strict && k % 2 == 0) || $urandom_range(0, 3) != 0)
				smp[CODE_W*k +: CODE_W] = lead;
			else
				smp[CODE_W*k +: CODE_W] = code_t'($urandom_range(0, NUM_CH - 1));
		end
		return smp;
	endfunction

	function automatic logic [SAMPLES_W-1:0] any_samples();
		return SAMPLES_W'($urandom);
	endfunction

	function automatic stim_row_t scan_row(input logic pin, input logic [SAMPLES_W-1:0] smp,
		input logic typed, input key_result_t want);
		stim_row_t row;
		row.pin = pin;
		row.smp = smp;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic void note_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Write a register, then read it back.
	task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
		logic [PDATA_W-1:0] keep;
		case (idx)
			REG_KEY_MAP: begin
				cfg_key_map = val;
				keep = '1;
			end
			REG_FLAG_ACTIVE_LOW: begin
				cfg_active_low = val[0];
				keep = 64'h1;
			end
			REG_STABLE_NEEDED: begin
				cfg_stable_needed = val[7:0];
				keep = 64'hff;
			end
			default: begin
				cfg_settle_scans = val[7:0];
				keep = 64'hff;
			end
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & keep) !== (val & keep)) begin
			$display("%0t: register %0d expected %0h actual %0h", $time, idx, val & keep,
				prdata & keep);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one scan beat, hold it until taken, then record what it should produce.
	task automatic play_scan(input logic pin, input logic [SAMPLES_W-1:0] smp,
		input logic typed, input key_result_t want);
		key_result_t predicted;
		while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
			scan_if.valid <= 1'b0;
			@(posedge clk);
		end
		scan_if.valid <= 1'b1;
		scan_if.flag_pin <= pin;
		scan_if.code_samples <= smp;
		do @(posedge clk); while (!scan_if.ready);
		qualify_scan(pin, smp, predicted);
		pending_keys.push_back(typed ? want : predicted);
		scans_sent++;
	endtask

	// Drop valid and hold off until every expected beat has come back.
	task automatic drain_keys();
		scan_if.valid <= 1'b0;
		while (pending_keys.size() != 0) @(posedge clk);
	endtask

	// Idle scans, a press with a drifting lead code and the odd bounce, then release.
	task automatic press_burst();
		int len;
		code_t lead;
		logic on;
		on = !cfg_active_low;
		repeat ($urandom_range(1, 2)) play_scan(!on, any_samples(), 1'b0, NO_KEY);
		if (cfg_settle_scans > 12)
			len = $urandom_range(1, 8);
		else
			len = cfg_settle_scans + $urandom_range(1, 12);
		lead = code_t'($urandom_range(0, NUM_CH - 1));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 15) lead = code_t'($urandom_range(0, NUM_CH - 1));
			if ($urandom_range(0, 99) < 4)
				play_scan(!on, any_samples(), 1'b0, NO_KEY);
			else
				play_scan(on, vote_mix(lead, 1'b0), 1'b0, NO_KEY);
		end
		play_scan(!on, any_samples(), 1'b0, NO_KEY);
	endtask

	// Reconfigure while idle, optionally run one long steady press, then random traffic.
	task automatic run_phase(input logic [PDATA_W-1:0] km, input logic fal, input byte_t sn,
		input byte_t ss, input int quota, input int hold);
		int goal;
		code_t lead;
		logic on;
		drain_keys();
		reg_write(REG_KEY_MAP, km);
		reg_write(REG_FLAG_ACTIVE_LOW, PDATA_W'(fal));
		reg_write(REG_STABLE_NEEDED, PDATA_W'(sn));
		reg_write(REG_SETTLE_SCANS, PDATA_W'(ss));
		on = !fal;
		if (hold > 0) begin
			lead = code_t'($urandom_range(0, NUM_CH - 1));
			play_scan(!on, any_samples(), 1'b0, NO_KEY);
			repeat (hold) play_scan(on, vote_mix(lead, 1'b1), 1'b0, NO_KEY);
			play_scan(!on, any_samples(), 1'b0, NO_KEY);
			// pause the sender until the long press has fully drained
			drain_keys();
		end
		goal = scans_sent + quota;
		while (scans_sent < goal) begin
			if ($urandom_range(0, 99) < 15)
				play_scan($urandom_range(0, 1), any_samples(), 1'b0, NO_KEY);
			else
				press_burst();
		end
	endtask

	// Result side: random stalls, and compare each beat with the oldest expectation.
	always @(posedge clk) begin
		key_result_t got;
		key_result_t want;
		key_if.ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
		if (arst_n && key_if.valid && key_if.ready) begin
			got = {key_if.key_valid, key_if.key_code, key_if.held_channel,
				key_if.release_valid, key_if.release_channel, key_if.release_key};
			if (pending_keys.size() == 0) begin
				$display("%0t: unexpected beat, actual %0h", $time, got);
				mismatch_count++;
			end else begin
				want = pending_keys.pop_front();
				note_field("key_valid", want.key_valid, got.key_valid);
				note_field("key_code", want.key_code, got.key_code);
				note_field("held_channel", want.held_channel, got.held_channel);
				note_field("release_valid", want.release_valid, got.release_valid);
				note_field("release_channel", want.release_channel, got.release_channel);
				note_field("release_key", want.release_key, got.release_key);
			end
		end
	end

	// Watchdog: end the run after too long without any beat or register access.
	always @(posedge clk) begin
		if ((scan_if.valid && scan_if.ready) || (key_if.valid && key_if.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		scan_if.valid = 1'b0;
		scan_if.flag_pin = 1'b1;
		scan_if.code_samples = '0;
		key_if.ready = 1'b0;
		steady = 1'b0;
		mismatch_count = 0;
		scans_sent = 0;
		quiet_cycles = 0;
		cfg_key_map = '0;
		cfg_active_low = 1'b1;
		cfg_stable_needed = STABLE_NEEDED_RST;
		cfg_settle_scans = SETTLE_SCANS_RST;
		prev_pressed = 1'b0;
		in_press = 1'b0;
		settle_left = '0;
		tracking_clear();

		// Directed scans, pin low means pressed, two settle scans, two equal votes.
		plan.push_back(scan_row(1'b1, 15'h0000, 1'b1, NO_KEY));
		plan.push_back(scan_row(1'b1, 15'h7fff, 1'b1, NO_KEY));
		// release inside the settle window: nothing usable, no event
		plan.push_back(scan_row(1'b0, 15'h7fff, 1'b1, NO_KEY));
		plan.push_back(scan_row(1'b1, 15'h0000, 1'b1, NO_KEY));
		plan.push_back(scan_row(1'b0, 15'h7fff, 1'b1, NO_KEY));
		plan.push_back(scan_row(1'b0, 15'h7fff, 1'b1, NO_KEY));
		plan.push_back(scan_row(1'b0, 15'h7fff, 1'b1, NO_KEY));
		plan.push_back(scan_row(1'b0, 15'h7fff, 1'b1,
			key_result_t'({1'b1, 8'h80, 4'd7, 1'b0, 3'd0, 8'h00})));
		// a held top channel is still reported on release
		plan.push_back(scan_row(1'b1, 15'h0000, 1'b1,
			key_result_t'({1'b0, 8'h00, NONE_CH, 1'b1, 3'd7, 8'h80})));
		// tied vote goes to the lower code, then the run breaks before release
		plan.push_back(scan_row(1'b0, pack5(5, 5, 3, 3, 1), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b0, pack5(5, 5, 3, 3, 1), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b0, pack5(5, 5, 3, 3, 1), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b0, pack5(1, 3, 5, 5, 3), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b0, pack5(0, 0, 0, 0, 0), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b0, pack5(6, 2, 6, 2, 4), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b1, 15'h7fff, 1'b0, NO_KEY));
		// all samples distinct: the lowest code wins
		plan.push_back(scan_row(1'b0, pack5(1, 2, 3, 4, 5), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b0, pack5(1, 2, 3, 4, 5), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b0, pack5(1, 2, 3, 4, 5), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b0, pack5(1, 1, 7, 7, 0), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b0, pack5(4, 4, 4, 1, 1), 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b1, 15'h5555, 1'b0, NO_KEY));
		plan.push_back(scan_row(1'b1, 15'h2aaa, 1'b0, NO_KEY));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_write(REG_KEY_MAP, DIRECTED_MAP);
		reg_write(REG_FLAG_ACTIVE_LOW, 64'h1);
		reg_write(REG_STABLE_NEEDED, 64'h2);
		reg_write(REG_SETTLE_SCANS, 64'h2);
		foreach (plan[i]) play_scan(plan[i].pin, plan[i].smp, plan[i].typed, plan[i].want);

		// Long press with no settling and a one-scan run: counters saturate.
		run_phase(64'h0, 1'b0, 8'd1, 8'd0, 30, 262);
		// Longest settle and run: every press ends inside the settle window.
		run_phase('1, 1'b1, 8'd255, 8'd255, 30, 0);
		// Zero run length: every scan counts as stable.
		run_phase({$urandom, $urandom}, 1'b0, 8'd0, 8'd1, 30, 0);
		// No idling on either side through this phase.
		steady = 1'b1;
		run_phase({$urandom, $urandom}, 1'b1, 8'd3, 8'd3, 30, 0);
		steady = 1'b0;
		run_phase({$urandom, $urandom}, $urandom_range(0, 1), byte_t'($urandom_range(1, 4)),
			byte_t'($urandom_range(0, 3)), 30, 0);

		drain_keys();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_keys.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
hw/rtl/tkq_pkg.sv
hw/rtl/tkq_ifs.sv
hw/rtl/tkq_vote_lane.sv
hw/rtl/tkq_vote_merge.sv
hw/rtl/tkq_hist.sv
hw/rtl/touch_key_code_qualifier_unit.sv
tb/sv/testbench.sv
